FILE: sv/osm_pkg.sv
// Shared sizes and control types for the order-statistic multiset unit.
// No dependencies; imported by osm_bound and the top unit (osm_ram does not use it).
package osm_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int RANK_W   = 10;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 80;

    // Item kinds carried on the input tuser bit
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    // Commands from the sequencer to the bound search unit
    typedef struct packed {
        logic start;
        logic step;
        logic strict;
    } bound_ctrl_t;

    // Status from the bound search unit back to the sequencer
    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] mid;
        logic [CNT_W-1:0]  lo;
    } bound_stat_t;

endpackage

FILE: sv/osm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module osm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/osm_bound.sv
// Binary search bound unit: holds the lo/hi window and the shared signed compare.
// Depends on osm_pkg.
module osm_bound (
    input  logic                        clk,
    input  logic                        rst_n,
    input  osm_pkg::bound_ctrl_t        ctrl,
    input  logic [osm_pkg::CNT_W-1:0]   count,
    input  logic signed [osm_pkg::KEY_W-1:0] key,
    input  logic signed [osm_pkg::KEY_W-1:0] rdata,
    output osm_pkg::bound_stat_t        stat
);
    import osm_pkg::*;

    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] mid_full;
    logic             go_right;

    // Midpoint of the window and the shared compare
    assign mid_full = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign go_right = ctrl.strict ? (rdata < key) : (rdata <= key);

    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctrl.start)
        begin
            lo_next = '0;
            hi_next = count;
        end
        else if (ctrl.step)
        begin
            if (go_right)
            begin
                lo_next = mid_full + CNT_W'(1);
            end
            else
            begin
                hi_next = mid_full;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= '0;
            hi_reg <= '0;
        end
        else
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign stat.done = (lo_reg == hi_reg);
    assign stat.mid  = mid_full[ADDR_W-1:0];
    assign stat.lo   = lo_reg;

endmodule

FILE: sv/order_statistic_multiset_unit.sv
// Order-statistic multiset: sorted store of signed keys with rank/select queries.
// Query: two binary searches (a read and a compare state per probe), then a rank read
// if the rank is in range. Insert: one search, then one entry moved up per cycle.
// One item at a time; a finished result waits in the output register. Reset empties
// the store at once (count cleared); no clearing pass. Depends on osm_pkg, osm_ram, osm_bound.
module order_statistic_multiset_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [31:0] key, [41:32] rank, [47:42] zero
    input  logic [osm_pkg::IN_W-1:0]  s_axis_tdata,
    // [0] op
    input  logic                      s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [10:0] count_less, [21:11] count_less_equal, [32:22] count_equal,
    // [64:33] value_at_rank, [65] rank_valid, [76:66] element_count,
    // [77] full_error, [79:78] zero
    output logic [osm_pkg::OUT_W-1:0] m_axis_tdata
);
    import osm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_RANK  = 3'd4;
    localparam logic [2:0] S_RCAP  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    op_reg, op_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [RANK_W-1:0]       rank_reg, rank_next;
    logic                    strict_reg, strict_next;
    logic [CNT_W-1:0]        lt_reg, lt_next;
    logic [CNT_W-1:0]        le_reg, le_next;
    logic [CNT_W-1:0]        sh_reg, sh_next;
    logic                    wpend_reg, wpend_next;
    logic [ADDR_W-1:0]       waddr_reg, waddr_next;
    logic signed [KEY_W-1:0] val_reg, val_next;
    logic                    rv_reg, rv_next;
    logic                    ferr_reg, ferr_next;
    logic                    ovalid_reg, ovalid_next;
    logic [OUT_W-1:0]        odata_reg, odata_next;

    logic                    in_acc;
    logic [CNT_W-1:0]        sh_dec;
    bound_ctrl_t             bctrl;
    bound_stat_t             bstat;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [KEY_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [KEY_W-1:0]        ram_rdata;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign sh_dec        = sh_reg - CNT_W'(1);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    osm_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    osm_bound u_bound (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (bctrl),
        .count (count_reg),
        .key   (key_reg),
        .rdata (ram_rdata),
        .stat  (bstat)
    );

    // Sequencer: search, shift, rank read and result hand-off
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        rank_next   = rank_reg;
        strict_next = strict_reg;
        lt_next     = lt_reg;
        le_next     = le_reg;
        sh_next     = sh_reg;
        wpend_next  = 1'b0;
        waddr_next  = waddr_reg;
        val_next    = val_reg;
        rv_next     = rv_reg;
        ferr_next   = ferr_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        bctrl       = '{start: 1'b0, step: 1'b0, strict: strict_reg};
        ram_we      = 1'b0;
        ram_waddr   = waddr_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = bstat.mid;

        // Drop the result once the sink takes it
        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next     = s_axis_tuser;
                    key_next    = s_axis_tdata[KEY_W-1:0];
                    rank_next   = s_axis_tdata[KEY_W+RANK_W-1:KEY_W];
                    lt_next     = '0;
                    le_next     = '0;
                    val_next    = '0;
                    rv_next     = 1'b0;
                    ferr_next   = 1'b0;
                    strict_next = (s_axis_tuser == OP_QUERY);
                    if (s_axis_tuser == OP_INSERT && count_reg >= CNT_W'(CAPACITY))
                    begin
                        ferr_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        bctrl.start = 1'b1;
                        state_next  = S_SRCH;
                    end
                end
            end
            S_SRCH:
            begin
                if (!bstat.done)
                begin
                    // Read the probe entry
                    state_next = S_CMP;
                end
                else if (strict_reg)
                begin
                    // Strict pass over: start the inclusive pass
                    lt_next      = bstat.lo;
                    strict_next  = 1'b0;
                    bctrl.start  = 1'b1;
                    bctrl.strict = 1'b0;
                end
                else if (op_reg == OP_INSERT)
                begin
                    le_next    = bstat.lo;
                    sh_next    = count_reg;
                    state_next = S_SHIFT;
                end
                else
                begin
                    le_next = bstat.lo;
                    if (CNT_W'(rank_reg) < count_reg)
                    begin
                        state_next = S_RANK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CMP:
            begin
                bctrl.step = 1'b1;
                state_next = S_SRCH;
            end
            S_SHIFT:
            begin
                // Move one entry up per cycle; the write follows the registered read via wpend_reg
                ram_raddr = sh_dec[ADDR_W-1:0];
                if (wpend_reg)
                begin
                    ram_we = 1'b1;
                end
                if (sh_reg > le_reg)
                begin
                    wpend_next = 1'b1;
                    waddr_next = sh_reg[ADDR_W-1:0];
                    sh_next    = sh_dec;
                end
                else if (!wpend_reg)
                begin
                    // Place the new key at its slot
                    ram_we     = 1'b1;
                    ram_waddr  = le_reg[ADDR_W-1:0];
                    ram_wdata  = key_reg;
                    count_next = count_reg + CNT_W'(1);
                    le_next    = '0;
                    state_next = S_DONE;
                end
            end
            S_RANK:
            begin
                ram_raddr  = rank_reg;
                state_next = S_RCAP;
            end
            S_RCAP:
            begin
                val_next   = ram_rdata;
                rv_next    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {2'b00, ferr_reg, count_reg, rv_reg, val_reg,
                                   le_reg - lt_reg, le_reg, lt_reg};
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            wpend_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            wpend_reg  <= wpend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        rank_reg   <= rank_next;
        strict_reg <= strict_next;
        lt_reg     <= lt_next;
        le_reg     <= le_next;
        sh_reg     <= sh_next;
        waddr_reg  <= waddr_next;
        val_reg    <= val_next;
        rv_reg     <= rv_next;
        ferr_reg   <= ferr_next;
        odata_reg  <= odata_next;
    end

    // Store never overfills
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    // Count only grows, by one, and only at the end of an insert
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            (count_reg == $past(count_reg) + CNT_W'(1) && $past(state_reg) == S_SHIFT))
        else $error("element count changed outside an insert");

    // A dropped insert reports no rank hit
    a_ferr_rank: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[77] |-> !m_axis_tdata[65])
        else $error("dropped insert reports a valid rank");

    // Strict bound never exceeds inclusive bound
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[10:0] <= m_axis_tdata[21:11])
        else $error("count_less above count_less_equal");

endmodule
